[rtl/core/rle_scanline_decoder_unit_macros.svh]
// ----------------------------------------------------------------------------
// rle_scanline_decoder_unit_macros
// Assertion macros used by the scanline decoder checker.
// ----------------------------------------------------------------------------
`ifndef RLE_SCANLINE_DECODER_UNIT_MACROS_SVH
`define RLE_SCANLINE_DECODER_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define RSD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("rsd assertion failed");

// next-cycle implication, disabled in reset
`define RSD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("rsd assertion failed");

`endif

[rtl/core/rsd_pkg.sv]
// ----------------------------------------------------------------------------
// rsd_pkg
// Types and constants of the run-length scanline decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rsd_pkg;

    localparam int unsigned MAX_LINE_WIDTH = 65535;
    localparam int unsigned QUEUE_DEPTH    = 2;

    localparam logic [6:0] COUNT_MASK   = 7'h7f;
    localparam int unsigned LITERAL_BIT = 7;

    localparam logic CFG_LINE_WIDTH   = 1'b0;
    localparam logic CFG_WIDE_SAMPLES = 1'b1;

    typedef enum logic [1:0] {
        PH_HEADER    = 2'd0,
        PH_LITERAL   = 2'd1,
        PH_REPLICATE = 2'd2,
        PH_IDLE      = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        OP_END     = 3'd0,
        OP_LIT     = 3'd1,
        OP_LIT_OVR = 3'd2,
        OP_REP     = 3'd3,
        OP_REP_OVR = 3'd4
    } t_op;

    typedef struct packed {
        logic [15:0] data_word;
        logic        line_start;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  pixel_value;
        logic [15:0] start_column;
        logic [6:0]  repeat_res;
        logic        line_done;
        logic        overrun_error;
    } t_out_item;

    typedef struct packed {
        logic [15:0] line_width;
        logic        wide_samples;
    } t_cfg;

    typedef struct packed {
        t_op         op;
        logic [7:0]  value;
        logic [15:0] column;
        logic [6:0]  count;
    } t_cmd;

endpackage

[rtl/core/rsd_front.sv]
// ----------------------------------------------------------------------------
// rsd_front
// Accepts stream items, tracks packet state and column, issues run commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rsd_front
    import rsd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_accept,
    input  t_in_item i_item,
    output logic     o_push,
    output t_cmd     o_cmd
);

    t_phase      r_phase, n_phase;
    logic [6:0]  r_left, n_left;
    logic [15:0] r_column, n_column;

    t_phase      ph_eff;
    logic [6:0]  left_eff;
    logic [15:0] col_eff;
    logic [15:0] width_eff;
    logic [15:0] room;
    logic [6:0]  count;
    logic [7:0]  sample;
    logic [6:0]  left_dec;
    logic        rep_over;

    always_comb begin
        ph_eff    = i_item.line_start ? PH_HEADER : r_phase;
        left_eff  = i_item.line_start ? 7'd0 : r_left;
        col_eff   = i_item.line_start ? 16'd0 : r_column;
        width_eff = (32'(i_cfg.line_width) > MAX_LINE_WIDTH) ? 16'(MAX_LINE_WIDTH)
                                                             : i_cfg.line_width;
        room      = (col_eff >= width_eff) ? 16'd0 : (width_eff - col_eff);
        count     = i_item.data_word[6:0] & COUNT_MASK;
        sample    = i_cfg.wide_samples ? i_item.data_word[15:8] : i_item.data_word[7:0];
        left_dec  = left_eff - 7'd1;
        rep_over  = ({9'd0, left_eff} > room);
    end

    always_comb begin
        n_phase  = r_phase;
        n_left   = r_left;
        n_column = r_column;
        if (i_accept) begin
            n_phase  = ph_eff;
            n_left   = left_eff;
            n_column = col_eff;
            unique case (ph_eff)
                PH_HEADER: begin
                    if (count == 7'd0) begin
                        n_phase = PH_IDLE;
                    end else begin
                        n_left  = count;
                        n_phase = i_item.data_word[LITERAL_BIT] ? PH_LITERAL : PH_REPLICATE;
                    end
                end
                PH_LITERAL: begin
                    if (room == 16'd0) begin
                        n_phase = PH_IDLE;
                    end else begin
                        n_column = col_eff + 16'd1;
                        n_left   = left_dec;
                        if (left_dec == 7'd0) begin
                            n_phase = PH_HEADER;
                        end
                    end
                end
                PH_REPLICATE: begin
                    if (rep_over) begin
                        n_column = col_eff + room;
                        n_phase  = PH_IDLE;
                    end else begin
                        n_column = col_eff + {9'd0, left_eff};
                        n_left   = 7'd0;
                        n_phase  = PH_HEADER;
                    end
                end
                PH_IDLE: begin
                    n_phase = PH_IDLE;
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        o_push       = 1'b0;
        o_cmd.op     = OP_END;
        o_cmd.value  = sample;
        o_cmd.column = col_eff;
        o_cmd.count  = left_eff;
        unique case (ph_eff)
            PH_HEADER: begin
                o_push = i_accept && (count == 7'd0);
                o_cmd.op = OP_END;
            end
            PH_LITERAL: begin
                o_push   = i_accept;
                o_cmd.op = (room == 16'd0) ? OP_LIT_OVR : OP_LIT;
            end
            PH_REPLICATE: begin
                o_push = i_accept;
                if (rep_over) begin
                    o_cmd.op    = OP_REP_OVR;
                    o_cmd.count = room[6:0];
                end else begin
                    o_cmd.op = OP_REP;
                end
            end
            PH_IDLE: begin
                o_push = 1'b0;
            end
            default: begin
                o_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_left   <= 7'd0;
            r_column <= 16'd0;
        end else begin
            r_phase  <= n_phase;
            r_left   <= n_left;
            r_column <= n_column;
        end
    end

endmodule

[rtl/core/rsd_queue.sv]
// ----------------------------------------------------------------------------
// rsd_queue
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rsd_queue
    import rsd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd,
    output logic o_full
);

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_pop;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

[rtl/core/rsd_back.sv]
// ----------------------------------------------------------------------------
// rsd_back
// Turns queued run commands into result items held in an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rsd_back
    import rsd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_valid,
    input  t_cmd      i_cmd,
    output logic      o_pop,
    output logic      o_out_valid,
    output t_out_item o_out_data,
    input  logic      i_out_stall
);

    logic      r_valid, n_valid;
    t_out_item r_data, n_data;
    logic      take;

    assign take        = !r_valid || !i_out_stall;
    assign o_pop       = take && i_cmd_valid;
    assign n_valid     = take ? i_cmd_valid : r_valid;
    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

    always_comb begin
        n_data.pixel_value   = i_cmd.value;
        n_data.start_column  = i_cmd.column;
        n_data.repeat_res    = i_cmd.count;
        n_data.line_done     = 1'b0;
        n_data.overrun_error = 1'b0;
        unique case (i_cmd.op)
            OP_END: begin
                n_data.pixel_value = 8'd0;
                n_data.repeat_res  = 7'd0;
                n_data.line_done   = 1'b1;
            end
            OP_LIT: begin
                n_data.repeat_res = 7'd1;
            end
            OP_LIT_OVR: begin
                n_data.repeat_res    = 7'd0;
                n_data.overrun_error = 1'b1;
            end
            OP_REP: begin
                n_data.repeat_res = i_cmd.count;
            end
            OP_REP_OVR: begin
                n_data.overrun_error = 1'b1;
            end
            default: begin
                n_data.repeat_res = 7'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= n_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

endmodule

[rtl/core/rle_scanline_decoder_unit.sv]
// One stream word is taken per clock while the input is not stalled. Header
// words other than the end packet, and words in an idle line, give no result;
// every other word gives one run item, which passes through the queue into the
// output register. Runs wait in a two-entry queue, so the input stalls exactly
// when that queue is full, which happens only after the output has stalled.
// line_start on an item restarts the line at column zero.
// ----------------------------------------------------------------------------
// rle_scanline_decoder_unit
// Run-length scanline decoder: front state tracker, run queue, result stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rle_scanline_decoder_unit
    import rsd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    input  t_in_item    i_in_data,
    output logic        o_in_stall,
    output logic        o_out_valid,
    output t_out_item   o_out_data,
    input  logic        i_out_stall
);

    t_cfg r_cfg;
    logic accept;
    logic push;
    t_cmd push_cmd;
    logic q_valid;
    t_cmd q_cmd;
    logic q_full;
    logic pop;

    assign o_in_stall = q_full;
    assign accept     = i_in_valid && !q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.line_width   <= 16'd1;
            r_cfg.wide_samples <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_LINE_WIDTH:   r_cfg.line_width   <= i_cfg_data;
                CFG_WIDE_SAMPLES: r_cfg.wide_samples <= i_cfg_data[0];
                default:          r_cfg <= r_cfg;
            endcase
        end
    end

    rsd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_accept (accept),
        .i_item   (i_in_data),
        .o_push   (push),
        .o_cmd    (push_cmd)
    );

    rsd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .o_full  (q_full)
    );

    rsd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

[rtl/core/rsd_checker.sv]
// ----------------------------------------------------------------------------
// rsd_checker
// Port-level checks on the result items of the scanline decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rle_scanline_decoder_unit_macros.svh"

module rsd_checker
    import rsd_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input t_out_item o_out_data,
    input logic      i_out_stall
);

    `RSD_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data))
    `RSD_ASSERT_NOW(a_done_clean, o_out_valid && o_out_data.line_done, o_out_data.repeat_res == 7'd0 && o_out_data.pixel_value == 8'd0 && !o_out_data.overrun_error)
    `RSD_ASSERT_NOW(a_run_nonzero, o_out_valid && !o_out_data.line_done && !o_out_data.overrun_error, o_out_data.repeat_res != 7'd0)

endmodule

bind rle_scanline_decoder_unit rsd_checker u_rsd_checker (.*);
